// File: design/scph_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// scph_pkg
// Shared types, codes and the arithmetic microprogram of the segment /
// convex polygon hit unit.
// ============================================================================
package scph_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEST   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REASON_HIT             = 3'd0,
        REASON_FEW_VERTICES    = 3'd1,
        REASON_PARALLEL        = 3'd2,
        REASON_OUTSIDE_SEGMENT = 3'd3,
        REASON_OUTSIDE_POLYGON = 3'd4
    } reason_t;

    localparam int MIN_VERTICES = 3;

    typedef enum logic [3:0] {
        OPA_N0, OPA_N1, OPA_N2,
        OPA_M0, OPA_M1, OPA_M2,
        OPA_T1, OPA_T2,
        OPA_D0, OPA_D1, OPA_D2
    } opa_t;

    typedef enum logic [2:0] {
        OPB_D0, OPB_D1, OPB_D2,
        OPB_F0, OPB_F1, OPB_F2,
        OPB_NP, OPB_MP
    } opb_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_N0, DST_N1, DST_N2,
        DST_DEN, DST_NUM,
        DST_M0, DST_M1, DST_M2,
        DST_T1, DST_T2,
        DST_VAL
    } dest_t;

    typedef enum logic [3:0] {
        LD_NONE,
        LD_V0,
        LD_D_V0,
        LD_F_V0,
        LD_SE,
        LD_VI,
        LD_D_VI,
        LD_F_SVI,
        LD_F_EVI,
        LD_NPMP
    } ld_t;

    typedef struct packed {
        opa_t  opa;
        opb_t  opb;
        logic  neg;
        dest_t dest;
        logic  seg_end;
    } uop_t;

    typedef struct packed {
        ld_t  ld;
        logic seg_load;
        logic mac_start;
        logic mac_step;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_done;
        logic den_zero;
        logic range_neg;
        logic val_zero;
        logic val_neg;
    } dp_stat_t;

    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UPC_NORMAL      = 5'd0;
    localparam logic [UPC_W-1:0] UPC_PLANE       = 5'd6;
    localparam logic [UPC_W-1:0] UPC_EDGE_NORMAL = 5'd15;
    localparam logic [UPC_W-1:0] UPC_START_SIDE  = 5'd21;
    localparam logic [UPC_W-1:0] UPC_END_SIDE    = 5'd24;

    function automatic uop_t mk_uop(input opa_t a, input opb_t b, input logic neg,
                                    input dest_t d, input logic last);
        uop_t u;
        u.opa     = a;
        u.opb     = b;
        u.neg     = neg;
        u.dest    = d;
        u.seg_end = last;
        return u;
    endfunction

    // Each entry adds or subtracts one product into the accumulator.
    function automatic uop_t uop_rom(input logic [UPC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:    u = mk_uop(OPA_D1, OPB_F2, 1'b0, DST_NONE, 1'b0);
            5'd1:    u = mk_uop(OPA_D2, OPB_F1, 1'b1, DST_N0,   1'b0);
            5'd2:    u = mk_uop(OPA_D2, OPB_F0, 1'b0, DST_NONE, 1'b0);
            5'd3:    u = mk_uop(OPA_D0, OPB_F2, 1'b1, DST_N1,   1'b0);
            5'd4:    u = mk_uop(OPA_D0, OPB_F1, 1'b0, DST_NONE, 1'b0);
            5'd5:    u = mk_uop(OPA_D1, OPB_F0, 1'b1, DST_N2,   1'b1);
            5'd6:    u = mk_uop(OPA_N0, OPB_F0, 1'b0, DST_NONE, 1'b0);
            5'd7:    u = mk_uop(OPA_N1, OPB_F1, 1'b0, DST_NONE, 1'b0);
            5'd8:    u = mk_uop(OPA_N2, OPB_F2, 1'b0, DST_NONE, 1'b0);
            5'd9:    u = mk_uop(OPA_N0, OPB_D0, 1'b1, DST_NONE, 1'b0);
            5'd10:   u = mk_uop(OPA_N1, OPB_D1, 1'b1, DST_NONE, 1'b0);
            5'd11:   u = mk_uop(OPA_N2, OPB_D2, 1'b1, DST_DEN,  1'b0);
            5'd12:   u = mk_uop(OPA_N0, OPB_F0, 1'b0, DST_NONE, 1'b0);
            5'd13:   u = mk_uop(OPA_N1, OPB_F1, 1'b0, DST_NONE, 1'b0);
            5'd14:   u = mk_uop(OPA_N2, OPB_F2, 1'b0, DST_NUM,  1'b1);
            5'd15:   u = mk_uop(OPA_N2, OPB_D1, 1'b0, DST_NONE, 1'b0);
            5'd16:   u = mk_uop(OPA_N1, OPB_D2, 1'b1, DST_M0,   1'b0);
            5'd17:   u = mk_uop(OPA_N0, OPB_D2, 1'b0, DST_NONE, 1'b0);
            5'd18:   u = mk_uop(OPA_N2, OPB_D0, 1'b1, DST_M1,   1'b0);
            5'd19:   u = mk_uop(OPA_N1, OPB_D0, 1'b0, DST_NONE, 1'b0);
            5'd20:   u = mk_uop(OPA_N0, OPB_D1, 1'b1, DST_M2,   1'b1);
            5'd21:   u = mk_uop(OPA_M0, OPB_F0, 1'b0, DST_NONE, 1'b0);
            5'd22:   u = mk_uop(OPA_M1, OPB_F1, 1'b0, DST_NONE, 1'b0);
            5'd23:   u = mk_uop(OPA_M2, OPB_F2, 1'b0, DST_T1,   1'b1);
            5'd24:   u = mk_uop(OPA_M0, OPB_F0, 1'b0, DST_NONE, 1'b0);
            5'd25:   u = mk_uop(OPA_M1, OPB_F1, 1'b0, DST_NONE, 1'b0);
            5'd26:   u = mk_uop(OPA_M2, OPB_F2, 1'b0, DST_T2,   1'b0);
            5'd27:   u = mk_uop(OPA_T1, OPB_NP, 1'b0, DST_NONE, 1'b0);
            5'd28:   u = mk_uop(OPA_T2, OPB_MP, 1'b0, DST_VAL,  1'b1);
            default: u = mk_uop(OPA_N0, OPB_D0, 1'b0, DST_NONE, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// File: design/scph_cmd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// scph_cmd_if
// Input channel: one operation item with a vertex or a segment.
// ============================================================================
interface scph_cmd_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;

    modport source (
        output valid, operation, start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

// File: design/scph_res_if.sv
`timescale 1ns / 1ps
// ============================================================================
// scph_res_if
// Result channel: one hit item per segment test.
// ============================================================================
interface scph_res_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [2:0] miss_reason;

    modport source (
        output valid, hit, miss_reason,
        input  ready
    );
    modport sink (
        input  valid, hit, miss_reason,
        output ready
    );
endinterface

// File: design/scph_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// scph_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module scph_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/scph_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// scph_datapath
// Vertex store, coordinate differences and a shared radix-16 multiply
// accumulate unit that evaluates the plane and edge products exactly.
// ============================================================================
module scph_datapath import scph_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 24,
    localparam int IDX_W = $clog2(MAX_VERTICES)
) (
    input  logic                         clk,
    input  dp_cmd_t                      cmd,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [IDX_W-1:0]             rd_addr,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] start_z,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] end_z,
    output dp_stat_t                     stat
);

    localparam int ACC_W = 7 * COORD_BITS + 20;
    localparam int VW    = 3 * COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]      wide_t;

    function automatic wide_t sx(input coord_t v);
        return ACC_W'(v);
    endfunction

    logic [VW-1:0] rd_data;
    coord_t        rd_c   [3];
    coord_t        in_st  [3];
    coord_t        in_en  [3];
    coord_t        v0_reg [3];
    coord_t        vi_reg [3];
    coord_t        st_reg [3];
    coord_t        en_reg [3];
    wide_t         d_reg  [3];
    wide_t         f_reg  [3];
    wide_t         n_reg  [3];
    wide_t         m_reg  [3];
    wide_t         den_reg;
    wide_t         num_reg;
    wide_t         np_reg;
    wide_t         mp_reg;
    wide_t         t1_reg;
    wide_t         t2_reg;
    wide_t         val_reg;
    logic [ACC_W-1:0] mcand_reg;
    wide_t         mplier_reg;
    logic [ACC_W-1:0] acc_reg;
    wide_t         opa_val;
    wide_t         opb_val;
    logic [ACC_W-1:0] partial;
    logic [ACC_W-1:0] term;
    logic [ACC_W-1:0] acc_sum;
    logic          fin_pos;
    logic          fin_neg;

    scph_ram #(
        .WIDTH(VW),
        .DEPTH(MAX_VERTICES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({start_z, start_y, start_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_c[0] = rd_data[COORD_BITS-1:0];
    assign rd_c[1] = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign rd_c[2] = rd_data[3*COORD_BITS-1:2*COORD_BITS];
    assign in_st[0] = start_x;
    assign in_st[1] = start_y;
    assign in_st[2] = start_z;
    assign in_en[0] = end_x;
    assign in_en[1] = end_y;
    assign in_en[2] = end_z;

    always_comb
    begin
        unique case (cmd.uop.opa)
            OPA_N0:  opa_val = n_reg[0];
            OPA_N1:  opa_val = n_reg[1];
            OPA_N2:  opa_val = n_reg[2];
            OPA_M0:  opa_val = m_reg[0];
            OPA_M1:  opa_val = m_reg[1];
            OPA_M2:  opa_val = m_reg[2];
            OPA_T1:  opa_val = t1_reg;
            OPA_T2:  opa_val = t2_reg;
            OPA_D0:  opa_val = d_reg[0];
            OPA_D1:  opa_val = d_reg[1];
            OPA_D2:  opa_val = d_reg[2];
            default: opa_val = '0;
        endcase
        unique case (cmd.uop.opb)
            OPB_D0:  opb_val = d_reg[0];
            OPB_D1:  opb_val = d_reg[1];
            OPB_D2:  opb_val = d_reg[2];
            OPB_F0:  opb_val = f_reg[0];
            OPB_F1:  opb_val = f_reg[1];
            OPB_F2:  opb_val = f_reg[2];
            OPB_NP:  opb_val = np_reg;
            OPB_MP:  opb_val = mp_reg;
            default: opb_val = '0;
        endcase
    end

    // The multiplier is consumed four bits a cycle from the bottom; once only
    // sign bits remain, a final -1 digit (or nothing) closes the product.
    assign fin_pos = (mplier_reg == '0);
    assign fin_neg = &mplier_reg;
    assign partial = mcand_reg * ACC_W'(mplier_reg[3:0]);

    always_comb
    begin
        priority if (fin_pos)
        begin
            term = '0;
        end
        else if (fin_neg)
        begin
            term = -mcand_reg;
        end
        else
        begin
            term = partial;
        end
        acc_sum = cmd.uop.neg ? (acc_reg - term) : (acc_reg + term);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seg_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                st_reg[k] <= in_st[k];
                en_reg[k] <= in_en[k];
            end
        end

        unique case (cmd.ld)
            LD_V0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v0_reg[k] <= rd_c[k];
                end
                acc_reg <= '0;
            end
            LD_D_V0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_reg[k] <= sx(rd_c[k]) - sx(v0_reg[k]);
                end
            end
            LD_F_V0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    f_reg[k] <= sx(rd_c[k]) - sx(v0_reg[k]);
                end
            end
            LD_SE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_reg[k] <= sx(st_reg[k]) - sx(v0_reg[k]);
                    f_reg[k] <= sx(en_reg[k]) - sx(v0_reg[k]);
                end
            end
            LD_VI:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    vi_reg[k] <= rd_c[k];
                end
            end
            LD_D_VI:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_reg[k] <= sx(rd_c[k]) - sx(vi_reg[k]);
                end
            end
            LD_F_SVI:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    f_reg[k] <= sx(st_reg[k]) - sx(vi_reg[k]);
                end
            end
            LD_F_EVI:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    f_reg[k] <= sx(en_reg[k]) - sx(vi_reg[k]);
                end
            end
            LD_NPMP:
            begin
                if (den_reg[ACC_W-1])
                begin
                    np_reg <= -num_reg;
                    mp_reg <= num_reg - den_reg;
                end
                else
                begin
                    np_reg <= num_reg;
                    mp_reg <= den_reg - num_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.mac_start)
        begin
            mcand_reg  <= opa_val;
            mplier_reg <= opb_val;
        end
        else if (cmd.mac_step)
        begin
            if (!(fin_pos || fin_neg))
            begin
                mcand_reg  <= mcand_reg << 4;
                mplier_reg <= mplier_reg >>> 4;
                acc_reg    <= acc_sum;
            end
            else if (cmd.uop.dest == DST_NONE)
            begin
                acc_reg <= acc_sum;
            end
            else
            begin
                acc_reg <= '0;
                unique case (cmd.uop.dest)
                    DST_N0:  n_reg[0] <= acc_sum;
                    DST_N1:  n_reg[1] <= acc_sum;
                    DST_N2:  n_reg[2] <= acc_sum;
                    DST_DEN: den_reg  <= acc_sum;
                    DST_NUM: num_reg  <= acc_sum;
                    DST_M0:  m_reg[0] <= acc_sum;
                    DST_M1:  m_reg[1] <= acc_sum;
                    DST_M2:  m_reg[2] <= acc_sum;
                    DST_T1:  t1_reg   <= acc_sum;
                    DST_T2:  t2_reg   <= acc_sum;
                    DST_VAL: val_reg  <= acc_sum;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign stat.mac_done  = fin_pos | fin_neg;
    assign stat.den_zero  = (den_reg == '0);
    assign stat.range_neg = np_reg[ACC_W-1] | mp_reg[ACC_W-1];
    assign stat.val_zero  = (val_reg == '0);
    assign stat.val_neg   = val_reg[ACC_W-1];

endmodule

// File: design/scph_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// scph_ctrl
// Controller: vertex count, handshakes, microprogram sequencing, edge walk
// and the result register.
// ============================================================================
module scph_ctrl import scph_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    localparam int IDX_W = $clog2(MAX_VERTICES),
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic [1:0]       operation,
    output logic             res_valid,
    input  logic             res_ready,
    output logic             hit,
    output logic [2:0]       miss_reason,
    output dp_cmd_t          dcmd,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output logic [IDX_W-1:0] rd_addr,
    input  dp_stat_t         stat
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_V0    = 15'b000000000000010,
        S_V1    = 15'b000000000000100,
        S_V2    = 15'b000000000001000,
        S_LDSE  = 15'b000000000010000,
        S_ISSUE = 15'b000000000100000,
        S_WAIT  = 15'b000000001000000,
        S_CHK   = 15'b000000010000000,
        S_CHK2  = 15'b000000100000000,
        S_EI    = 15'b000001000000000,
        S_EJ    = 15'b000010000000000,
        S_ELS   = 15'b000100000000000,
        S_ELE   = 15'b001000000000000,
        S_EVAL  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             prev_valid_reg, prev_valid_next;
    logic             prev_neg_reg, prev_neg_next;
    reason_t          reason_reg, reason_next;
    logic             out_valid_reg, out_valid_next;
    reason_t          out_reason_reg, out_reason_next;
    uop_t             cur_uop;
    logic [CNT_W-1:0] idx_inc;
    logic             last_edge;

    assign cur_uop   = uop_rom(upc_reg);
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign last_edge = (idx_inc == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        upc_next        = upc_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        prev_valid_next = prev_valid_reg;
        prev_neg_next   = prev_neg_reg;
        reason_next     = reason_reg;
        out_valid_next  = out_valid_reg & ~res_ready;
        out_reason_next = out_reason_reg;
        cmd_ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        rd_addr         = '0;
        dcmd.ld         = LD_NONE;
        dcmd.seg_load   = 1'b0;
        dcmd.mac_start  = 1'b0;
        dcmd.mac_step   = 1'b0;
        dcmd.uop        = cur_uop;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_TEST:
                        begin
                            dcmd.seg_load = 1'b1;
                            if (count_reg < CNT_W'(MIN_VERTICES))
                            begin
                                reason_next = REASON_FEW_VERTICES;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_V0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_V0:
            begin
                dcmd.ld    = LD_V0;
                rd_addr    = IDX_W'(1);
                state_next = S_V1;
            end
            S_V1:
            begin
                dcmd.ld    = LD_D_V0;
                rd_addr    = IDX_W'(2);
                state_next = S_V2;
            end
            S_V2:
            begin
                dcmd.ld    = LD_F_V0;
                upc_next   = UPC_NORMAL;
                ret_next   = S_LDSE;
                state_next = S_ISSUE;
            end
            S_LDSE:
            begin
                dcmd.ld    = LD_SE;
                upc_next   = UPC_PLANE;
                ret_next   = S_CHK;
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                dcmd.mac_start = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                dcmd.mac_step = 1'b1;
                if (stat.mac_done)
                begin
                    upc_next   = upc_reg + UPC_W'(1);
                    state_next = cur_uop.seg_end ? ret_reg : S_ISSUE;
                end
            end
            S_CHK:
            begin
                dcmd.ld = LD_NPMP;
                if (stat.den_zero)
                begin
                    reason_next = REASON_PARALLEL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                if (stat.range_neg)
                begin
                    reason_next = REASON_OUTSIDE_SEGMENT;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next        = '0;
                    prev_valid_next = 1'b0;
                    rd_addr         = '0;
                    state_next      = S_EI;
                end
            end
            S_EI:
            begin
                dcmd.ld    = LD_VI;
                rd_addr    = last_edge ? '0 : idx_inc[IDX_W-1:0];
                state_next = S_EJ;
            end
            S_EJ:
            begin
                dcmd.ld    = LD_D_VI;
                upc_next   = UPC_EDGE_NORMAL;
                ret_next   = S_ELS;
                state_next = S_ISSUE;
            end
            S_ELS:
            begin
                dcmd.ld    = LD_F_SVI;
                upc_next   = UPC_START_SIDE;
                ret_next   = S_ELE;
                state_next = S_ISSUE;
            end
            S_ELE:
            begin
                dcmd.ld    = LD_F_EVI;
                upc_next   = UPC_END_SIDE;
                ret_next   = S_EVAL;
                state_next = S_ISSUE;
            end
            S_EVAL:
            begin
                if (stat.val_zero || (prev_valid_reg && (prev_neg_reg != stat.val_neg)))
                begin
                    reason_next = REASON_OUTSIDE_POLYGON;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_valid_next = 1'b1;
                    prev_neg_next   = stat.val_neg;
                    if (last_edge)
                    begin
                        reason_next = REASON_HIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc[IDX_W-1:0];
                        rd_addr    = idx_inc[IDX_W-1:0];
                        state_next = S_EI;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_reason_next = reason_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            upc_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            prev_valid_reg <= 1'b0;
            prev_neg_reg   <= 1'b0;
            reason_reg     <= REASON_HIT;
            out_valid_reg  <= 1'b0;
            out_reason_reg <= REASON_HIT;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            upc_reg        <= upc_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            prev_valid_reg <= prev_valid_next;
            prev_neg_reg   <= prev_neg_next;
            reason_reg     <= reason_next;
            out_valid_reg  <= out_valid_next;
            out_reason_reg <= out_reason_next;
        end
    end

    assign res_valid   = out_valid_reg;
    assign hit         = (out_reason_reg == REASON_HIT);
    assign miss_reason = out_reason_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_issue_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ISSUE |=> state_reg == S_WAIT)
        else $error("product issued without a wait phase");

    a_edge_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> CNT_W'(idx_reg) < count_reg)
        else $error("edge index beyond stored vertices");

    a_test_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_V0 |-> count_reg >= CNT_W'(MIN_VERTICES))
        else $error("plane set up with too few vertices");

endmodule

// File: design/segment_convex_polygon_hit_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_convex_polygon_hit_unit
// Stores a convex polygon and tests segments against it in exact integers.
// ============================================================================
// Channel  Role    Item
// cmd      sink    operation, start_x/y/z, end_x/y/z
// res      source  hit, miss_reason (one item per test)
//
// Clear and append finish as soon as they are taken. A test's plane setup and
// its per-vertex edge checks run on the single shared multiply-accumulate unit,
// which retires four multiplier bits a cycle; smaller operands finish sooner.
// Reset clears the vertex count and the result register; vertex storage is
// not cleared. A new item is taken while a result waits; a finished test
// holds until the result register is free.
// ============================================================================
module segment_convex_polygon_hit_unit import scph_pkg::*; #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 24
) (
    input logic        clk,
    input logic        rst_n,
    scph_cmd_if.sink   cmd,
    scph_res_if.source res
);

    localparam int IDX_W = $clog2(MAX_VERTICES);

    dp_cmd_t          dcmd;
    dp_stat_t         stat;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    scph_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_ready   (cmd.ready),
        .operation   (cmd.operation),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .hit         (res.hit),
        .miss_reason (res.miss_reason),
        .dcmd        (dcmd),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .stat        (stat)
    );

    scph_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk     (clk),
        .cmd     (dcmd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .start_x (cmd.start_x),
        .start_y (cmd.start_y),
        .start_z (cmd.start_z),
        .end_x   (cmd.end_x),
        .end_y   (cmd.end_y),
        .end_z   (cmd.end_z),
        .stat    (stat)
    );

endmodule
